### rtl/core/trle_pkg.sv
// shared constants and types for the transparent run-length encoder
package trle_pkg;

  localparam int MAX_RUN_DEF = 127;
  localparam int LANES       = 8;

  localparam logic [15:0] ROW_WIDTH_RESET = 16'd256;
  localparam logic [7:0]  ROW_END_CODE    = 8'h80;
  localparam logic [7:0]  CLEAR_RUN_FLAG  = 8'h80;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HDR   = 6'b000010,
    S_PIX   = 6'b000100,
    S_UPD   = 6'b001000,
    S_MARK  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

endpackage

### rtl/core/transparent_run_length_encoder.sv
// transparent run-length encoder: top level with run buffer memory and byte packer
//
// Input channel s_*: one 8-bit palette pixel per word, row order, 0 is transparent.
// Output channel m_*: up to eight encoded bytes per word, lane 0 first, with the
// byte count in tdata and tlast on the final word that one pixel causes. A pixel
// that only extends a run gives no output word.
// cfg_wr_en / cfg_wr_data set the row width (0 means 65536); write it while idle.
// Opaque pixels are held in a run buffer memory with a registered read until the run
// closes; the buffer is then read back one entry per cycle while the packer takes bytes.
// A pixel that emits bytes moves them one at a time over the single byte-wide path out
// of the buffer into the packer, and then hands over the last word.
// A new pixel is taken only once the previous one has left all its bytes in the
// packer or output register. When the receiver stalls, the output register holds
// its word and the packer fills up to eight bytes before the encoder waits.
// rst (synchronous) clears the row position, the open run, the packer and the output
// valid and sets the row width to 256; the run buffer itself is not cleared.
module transparent_run_length_encoder #(
  parameter int MAX_RUN = trle_pkg::MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,      // [63:0] byte_0..byte_7, [67:64] byte_count, rest zero
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int CW = $clog2(MAX_RUN + 1);
  localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  trle_pkg::state_t state;

  logic [15:0]   row_width;
  logic [15:0]   column;
  logic          run_open;
  logic          run_is_clear;
  logic [CW-1:0] run_count;
  logic [CW-1:0] idx;
  logic          phase;
  logic [7:0]    px;

  logic [7:0]    run_mem [MAX_RUN];
  logic [7:0]    mem_q;

  logic [7:0]    lane [trle_pkg::LANES];
  logic [3:0]    cnt;

  logic          push_req;
  logic [7:0]    push_byte;
  logic          out_free;
  logic          word_full;
  logic          push_ok;
  logic          flush_go;
  logic          load_out;
  logic [63:0]   word_bytes;
  logic [16:0]   col_inc;
  logic [16:0]   width_ext;
  logic          row_end;
  logic          clear_px;
  logic          close_now;
  logic [CW-1:0] count_base;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] idx_inc;
  logic          last_pix;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign s_tready = (state == trle_pkg::S_IDLE);

  // byte source for the packer
  always_comb begin
    push_req  = 1'b0;
    push_byte = 8'h00;
    case (state)
      trle_pkg::S_HDR: begin
        push_req  = 1'b1;
        push_byte = run_is_clear ? (trle_pkg::CLEAR_RUN_FLAG | 8'(run_count)) : 8'(run_count);
      end
      trle_pkg::S_PIX: begin
        push_req  = 1'b1;
        push_byte = mem_q;
      end
      trle_pkg::S_MARK: begin
        push_req  = 1'b1;
        push_byte = trle_pkg::ROW_END_CODE;
      end
      default: begin
      end
    endcase
  end

  assign out_free  = !m_tvalid || m_tready;
  assign word_full = (cnt == 4'(trle_pkg::LANES));
  assign push_ok   = push_req && (!word_full || out_free);
  assign flush_go  = (state == trle_pkg::S_FLUSH) && (cnt != 4'd0) && out_free;
  assign load_out  = (push_ok && word_full) || flush_go;

  always_comb begin
    for (int k = 0; k < trle_pkg::LANES; k++) begin
      word_bytes[8*k +: 8] = (4'(k) < cnt) ? lane[k] : 8'h00;
    end
  end

  assign col_inc   = {1'b0, column} + 17'd1;
  assign width_ext = {(row_width == 16'd0), row_width};
  assign row_end   = (col_inc >= width_ext);

  assign clear_px  = (px == 8'h00);
  assign close_now = run_open &&
                     (((s_tdata == 8'h00) != run_is_clear) || (run_count >= CW'(MAX_RUN)));

  assign count_base = run_open ? run_count : '0;
  assign count_inc  = CW'(count_base + CW'(1));
  assign idx_inc    = CW'(idx + CW'(1));
  assign last_pix   = (idx_inc == run_count);

  // buffer write happens in its own state, never in the same cycle as a read
  assign mem_we  = (state == trle_pkg::S_UPD) && !clear_px;
  assign wr_addr = count_base[AW-1:0];
  assign rd_en   = push_ok && (((state == trle_pkg::S_HDR) && !run_is_clear) ||
                               ((state == trle_pkg::S_PIX) && !last_pix));
  assign rd_addr = (state == trle_pkg::S_HDR) ? '0 : idx_inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      run_mem[wr_addr] <= px;
    end
    if (rd_en) begin
      mem_q <= run_mem[rd_addr];
    end
  end

  // packer lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
    end else if (push_ok) begin
      if (word_full) begin
        lane[0] <= push_byte;
        cnt     <= 4'd1;
      end else begin
        lane[cnt[2:0]] <= push_byte;
        cnt            <= cnt + 4'd1;
      end
    end else if (flush_go) begin
      cnt <= 4'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) begin
      m_tdata <= {4'd0, cnt, word_bytes};
      m_tlast <= flush_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= trle_pkg::ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= trle_pkg::S_IDLE;
      column       <= 16'd0;
      run_open     <= 1'b0;
      run_is_clear <= 1'b0;
      run_count    <= '0;
      phase        <= 1'b0;
    end else begin
      case (state)
        trle_pkg::S_IDLE: begin
          if (s_tvalid) begin
            px    <= s_tdata;
            phase <= 1'b0;
            state <= close_now ? trle_pkg::S_HDR : trle_pkg::S_UPD;
          end
        end
        trle_pkg::S_HDR: begin
          if (push_ok) begin
            if (!run_is_clear) begin
              idx   <= '0;
              state <= trle_pkg::S_PIX;
            end else if (!phase) begin
              run_open <= 1'b0;
              state    <= trle_pkg::S_UPD;
            end else begin
              state <= trle_pkg::S_MARK;
            end
          end
        end
        trle_pkg::S_PIX: begin
          if (push_ok) begin
            if (!last_pix) begin
              idx <= idx_inc;
            end else if (!phase) begin
              run_open <= 1'b0;
              state    <= trle_pkg::S_UPD;
            end else begin
              state <= trle_pkg::S_MARK;
            end
          end
        end
        trle_pkg::S_UPD: begin
          run_is_clear <= clear_px;
          run_count    <= count_inc;
          run_open     <= !row_end;
          column       <= row_end ? 16'd0 : col_inc[15:0];
          if (row_end) begin
            // a transparent run at the end of a row is dropped
            phase <= 1'b1;
            state <= clear_px ? trle_pkg::S_MARK : trle_pkg::S_HDR;
          end else begin
            state <= (cnt == 4'd0) ? trle_pkg::S_IDLE : trle_pkg::S_FLUSH;
          end
        end
        trle_pkg::S_MARK: begin
          if (push_ok) begin
            state <= trle_pkg::S_FLUSH;
          end
        end
        trle_pkg::S_FLUSH: begin
          if ((cnt == 4'd0) || out_free) begin
            state <= trle_pkg::S_IDLE;
          end
        end
        default: begin
          state <= trle_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_pix_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == trle_pkg::S_PIX) |-> (idx < run_count))
    else $error("run buffer read beyond open run");

  a_word_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[67:64] != 4'd0) && (m_tdata[67:64] <= 4'(trle_pkg::LANES))))
    else $error("output word with bad byte count");

  a_one_pixel: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second pixel taken while one is in progress");

  a_packer_fill: assert property (@(posedge clk) disable iff (rst)
    cnt <= 4'(trle_pkg::LANES))
    else $error("packer overfilled");

endmodule

### sim/transparent_run_length_encoder_tb.sv
// self-checking testbench for the transparent run-length encoder
`timescale 1ns / 1ps

module transparent_run_length_encoder_tb;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 32;
  localparam int TOTAL_ITEMS   = 430;
  localparam int QUIET_ITEMS   = 60;

  typedef struct packed {
    logic             last;
    logic [3:0]       count;
    logic [7:0][7:0]  lanes;
  } enc_word_t;

  class trle_scoreboard;
    logic [15:0]  row_width;
    int unsigned  column;
    bit           run_open;
    bit           run_clear;
    logic [6:0]   run_len;
    logic [7:0]   run_buf[127];
    logic [7:0]   code_bytes[$];
    enc_word_t    expected_words[$];
    int           errors;

    function new();
      row_width = trle_pkg::ROW_WIDTH_RESET;
      column    = 0;
      run_open  = 1'b0;
      run_clear = 1'b0;
      run_len   = '0;
      errors    = 0;
    endfunction

    function void set_row_width(logic [15:0] w);
      row_width = w;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // a trailing transparent run is dropped at the end of a row
    function void close_run(bit at_row_end);
      if (!run_open) return;
      if (run_clear) begin
        if (!at_row_end) code_bytes.push_back(trle_pkg::CLEAR_RUN_FLAG + {1'b0, run_len});
      end else begin
        code_bytes.push_back({1'b0, run_len});
        for (int i = 0; i < run_len; i++) code_bytes.push_back(run_buf[i]);
      end
      run_open  = 1'b0;
      run_clear = 1'b0;
      run_len   = '0;
    endfunction

    function void note_pixel(logic [7:0] px);
      bit          clear;
      int unsigned width;
      int          n_words;
      enc_word_t   w;
      clear = (px == 8'h00);
      width = (row_width == 16'd0) ? 32'd65536 : 32'(row_width);
      code_bytes.delete();
      if (run_open && (clear != run_clear || run_len >= trle_pkg::MAX_RUN_DEF))
        close_run(1'b0);
      if (!run_open) begin
        run_open  = 1'b1;
        run_clear = clear;
        run_len   = '0;
      end
      if (!clear && run_len < 127) run_buf[run_len] = px;
      run_len = run_len + 7'd1;
      column = column + 1;
      if (column >= width) begin
        close_run(1'b1);
        code_bytes.push_back(trle_pkg::ROW_END_CODE);
        column = 0;
      end
      column &= 32'hffff;
      n_words = (code_bytes.size() + trle_pkg::LANES - 1) / trle_pkg::LANES;
      for (int r = 0; r < n_words; r++) begin
        w = '0;
        for (int k = 0; k < trle_pkg::LANES; k++) begin
          if (r * trle_pkg::LANES + k < code_bytes.size()) begin
            w.lanes[k] = code_bytes[r * trle_pkg::LANES + k];
            w.count    = w.count + 4'd1;
          end
        end
        w.last = (r == n_words - 1);
        expected_words.push_back(w);
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [71:0] data, logic last);
      enc_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h last %b", data, last));
      end else begin
        w = expected_words.pop_front();
        for (int k = 0; k < trle_pkg::LANES; k++) begin
          if (data[8 * k +: 8] !== w.lanes[k])
            report($sformatf("byte_%0d got %h want %h", k, data[8 * k +: 8], w.lanes[k]));
        end
        if (data[67:64] !== w.count)
          report($sformatf("byte_count got %0d want %0d", data[67:64], w.count));
        if (last !== w.last)
          report($sformatf("last got %b want %b", last, w.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  trle_scoreboard sb;
  bit hold_req = 1'b0;
  bit no_idle  = 1'b0;
  int items_sent = 0;

  transparent_run_length_encoder u_top (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // valid stays high from one word to the next unless a gap is taken
  task automatic send_pixel(input logic [7:0] px);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_pixel(px);
    items_sent++;
  endtask

  function automatic logic [7:0] opaque_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'hff;
      1:       return 8'h01;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_run(input bit clear, input int len);
    for (int i = 0; i < len && items_sent < TOTAL_ITEMS; i++)
      send_pixel(clear ? 8'h00 : opaque_pixel());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [15:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    sb.set_row_width(w);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return 16'd2;
      2:       return 16'($urandom_range(3, 8));
      3:       return 16'($urandom_range(9, 40));
      4:       return 16'($urandom_range(41, 200));
      5:       return 16'hffff;
      6:       return 16'h0000;
      7:       return 16'($urandom_range(255, 257));
      default: return 16'($urandom_range(3, 30));
    endcase
  endfunction

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) sb.check_word(m_tdata, m_tlast);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (no_idle) stall_left = 0;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL transparent_run_length_encoder");
    $finish;
  end

  initial begin
    int phase_end;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default width, row stays open across the next write
    send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'h07);
    send_pixel(8'hff); send_pixel(8'h01); send_pixel(8'h00);
    wait_drained();
    // one pixel per row, the open row closes on the first pixel
    write_row_width(16'd1);
    send_pixel(8'h00); send_pixel(8'hff); send_pixel(8'h00);
    send_pixel(8'h80); send_pixel(8'h01);
    wait_drained();
    write_row_width(16'hffff);
    send_pixel(8'h80); send_pixel(8'h00); send_pixel(8'h00);
    send_pixel(8'h01); send_pixel(8'h7f);
    wait_drained();
    // zero means 65536 pixels per row
    write_row_width(16'h0000);
    send_pixel(8'hff); send_pixel(8'hff); send_pixel(8'h00);
    send_pixel(8'h55); send_pixel(8'haa);
    wait_drained();
    // trailing transparent run is dropped
    write_row_width(16'd3);
    send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'h00);
    send_pixel(8'h09); send_pixel(8'h00); send_pixel(8'h00);
    wait_drained();

    // every pixel makes a word, so a held output backs up to the input
    write_row_width(16'd1);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_drained();

    // full-length run closed by the run limit on the last pixel of a row: the longest burst of words
    write_row_width(16'd128);
    send_run(1'b0, 128);
    wait_drained();

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
      write_row_width(pick_width());
      phase_end = items_sent + $urandom_range(12, 40);
      while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
        case ($urandom_range(0, 19))
          0:       send_pixel(8'($urandom));
          1:       send_run(bit'($urandom_range(0, 1)), $urandom_range(120, 135));
          2, 3, 4: send_run(bit'($urandom_range(0, 1)), $urandom_range(9, 40));
          default: send_run($urandom_range(0, 2) == 0, $urandom_range(1, 8));
        endcase
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS transparent_run_length_encoder");
    end else begin
      $display("FAIL transparent_run_length_encoder");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/trle_pkg.sv
rtl/core/transparent_run_length_encoder.sv
sim/transparent_run_length_encoder_tb.sv
